@@ sv/tcw_pkg.sv @@
// Package for the text console writer: geometry, character codes, op codes,
// shared structs and the cell offset function. No dependencies.
package tcw_pkg;

	// Screen geometry
	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int TAB_STEP   = 10;
	localparam int CELL_COUNT = ROWS * COLUMNS;

	// Field widths, fixed by the port definitions
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int ADDR_W = 11;
	localparam int ATTR_W = 8;
	localparam int PROT_W = 5;
	localparam int CHAR_W = 8;
	localparam int WORD_W = 16;
	localparam int CFG_IW = 2;
	localparam int CFG_DW = 8;

	// Character codes
	localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

	// Configuration register indexes
	localparam logic [CFG_IW-1:0] CFG_ATTR = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_PROT = 2'd1;

	// Item operations
	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	// Cursor update for a put item
	typedef struct packed {
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic              cell_we;
		logic [ADDR_W-1:0] cell_addr;
		logic              scroll;
	} cursor_upd_t;

	// One result item
	typedef struct packed {
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [ADDR_W-1:0] offset;
		logic [WORD_W-1:0] word;
		logic              scroll;
	} result_t;

	// row*COLUMNS+col, one bit wider than a cell address for range checks
	function automatic logic [ADDR_W:0] cell_offset(input logic [ROW_W-1:0] row,
	                                                 input logic [COL_W-1:0] col);
		logic [ADDR_W:0] base;
		base = (ADDR_W+1)'(row) * (ADDR_W+1)'(COLUMNS);
		return base + (ADDR_W+1)'(col);
	endfunction

endpackage

@@ sv/tcw_cursor.sv @@
// Cursor advance for a put item: newline, tab clamp, column and row wrap,
// scroll check and the cell write address. Depends on tcw_pkg.
module tcw_cursor (
	input  logic [tcw_pkg::COL_W-1:0]  col,
	input  logic [tcw_pkg::ROW_W-1:0]  row,
	input  logic [tcw_pkg::CHAR_W-1:0] char_code,
	output tcw_pkg::cursor_upd_t       upd
);

	logic [tcw_pkg::COL_W:0]  col_inc;
	logic [tcw_pkg::COL_W:0]  col_tab;
	logic [tcw_pkg::ROW_W:0]  row_inc;
	logic [tcw_pkg::ROW_W:0]  row_wrap;
	logic [tcw_pkg::ADDR_W:0] addr_full;

	always_comb begin
		col_inc   = {1'b0, col} + (tcw_pkg::COL_W+1)'(1);
		col_tab   = {1'b0, col} + (tcw_pkg::COL_W+1)'(tcw_pkg::TAB_STEP);
		row_inc   = {1'b0, row} + (tcw_pkg::ROW_W+1)'(1);
		row_wrap  = (row_inc >= (tcw_pkg::ROW_W+1)'(tcw_pkg::ROWS)) ? '0 : row_inc;
		addr_full = tcw_pkg::cell_offset(row, col);

		upd.col       = col;
		upd.row       = row;
		upd.cell_we   = 1'b0;
		upd.cell_addr = addr_full[tcw_pkg::ADDR_W-1:0];
		upd.scroll    = 1'b0;

		if (char_code == tcw_pkg::CH_NEWLINE) begin
			upd.col    = '0;
			upd.scroll = row_inc >= (tcw_pkg::ROW_W+1)'(tcw_pkg::ROWS - 1);
			upd.row    = row_inc[tcw_pkg::ROW_W-1:0];
		end else if (char_code == tcw_pkg::CH_TAB) begin
			// clamp at the width; a column equal to the width is legal
			if (col_tab > (tcw_pkg::COL_W+1)'(tcw_pkg::COLUMNS))
				upd.col = tcw_pkg::COL_W'(tcw_pkg::COLUMNS);
			else
				upd.col = col_tab[tcw_pkg::COL_W-1:0];
			upd.scroll = {1'b0, row} >= (tcw_pkg::ROW_W+1)'(tcw_pkg::ROWS - 1);
		end else begin
			upd.cell_we = addr_full < (tcw_pkg::ADDR_W+1)'(tcw_pkg::CELL_COUNT);
			if (col_inc >= (tcw_pkg::COL_W+1)'(tcw_pkg::COLUMNS)) begin
				upd.col    = '0;
				upd.row    = row_wrap[tcw_pkg::ROW_W-1:0];
				upd.scroll = row_wrap >= (tcw_pkg::ROW_W+1)'(tcw_pkg::ROWS - 1);
			end else begin
				upd.col = col_inc[tcw_pkg::COL_W-1:0];
			end
		end

		// the scroll leaves the cursor on the line above the last
		if (upd.scroll)
			upd.row = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 2);
	end

endmodule

@@ sv/text_console_writer_core.sv @@
// Top level of the text console writer: cell store, sequencer for read,
// scroll and clear, result register with a hold slot. Depends on tcw_pkg, tcw_cursor.
//
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_ready    op, char_code, cell_index
//  out      source     out_valid / out_ready  cursor_col, cursor_row, cursor_offset,
//                                             cell_word, did_scroll
//  cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A put that does not scroll returns its result from ST_IDLE; a read passes through
// ST_READ for the store's registered read. A scroll copies (ROWS-1-keep)*COLUMNS cells
// through the single store port pair, one a cycle, then clears the last row; with
// every row but the last protected nothing is copied. A clear writes all 2000 cells.
// No clearing pass after reset; the store holds garbage until a clear item.
// in_ready is low while a sequence runs or while the hold slot is full.
module text_console_writer_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  op,
	input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
	input  logic [tcw_pkg::ADDR_W-1:0]  cell_index,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [tcw_pkg::COL_W-1:0]   cursor_col,
	output logic [tcw_pkg::ROW_W-1:0]   cursor_row,
	output logic [tcw_pkg::ADDR_W-1:0]  cursor_offset,
	output logic [tcw_pkg::WORD_W-1:0]  cell_word,
	output logic                        did_scroll,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [tcw_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [tcw_pkg::CFG_DW-1:0]  cfg_data
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_READ = 5'b00010,
		ST_COPY = 5'b00100,
		ST_ZERO = 5'b01000,
		ST_FILL = 5'b10000
	} state_t;

	localparam logic [tcw_pkg::ADDR_W-1:0] LAST_CELL =
		tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1);
	localparam logic [tcw_pkg::ADDR_W-1:0] LAST_BASE =
		tcw_pkg::ADDR_W'((tcw_pkg::ROWS - 1) * tcw_pkg::COLUMNS);
	localparam logic [tcw_pkg::PROT_W-1:0] KEEP_MAX = tcw_pkg::PROT_W'(tcw_pkg::ROWS - 1);

	state_t                       state_q, state_d;
	logic [tcw_pkg::COL_W-1:0]    col_q, col_d;
	logic [tcw_pkg::ROW_W-1:0]    row_q, row_d;
	logic [tcw_pkg::ATTR_W-1:0]   attr_q;
	logic [tcw_pkg::PROT_W-1:0]   prot_q;
	logic [tcw_pkg::ADDR_W-1:0]   cnt_q, cnt_d;
	logic [tcw_pkg::WORD_W-1:0]   blank_q, blank_d;
	logic                         rd_ok_q, rd_ok_d;
	logic                         wr_v_s1, wr_v_d;
	logic [tcw_pkg::ADDR_W-1:0]   wr_addr_s1, wr_addr_d;

	logic                         out_valid_q, hold_valid_q;
	tcw_pkg::result_t             out_q, hold_q, res;
	logic                         res_fire, out_take, accept;

	tcw_pkg::cursor_upd_t         upd;
	logic [tcw_pkg::PROT_W-1:0]   keep;
	logic [tcw_pkg::ADDR_W:0]     copy_start;
	logic [tcw_pkg::ADDR_W:0]     res_offset;

	// cell store signals
	logic [tcw_pkg::WORD_W-1:0]   cells_mem [tcw_pkg::CELL_COUNT];
	logic                         mem_we, rd_en;
	logic [tcw_pkg::ADDR_W-1:0]   mem_waddr, rd_addr;
	logic [tcw_pkg::WORD_W-1:0]   mem_wdata, rdata_q;

	tcw_cursor u_cursor (
		.col       (col_q),
		.row       (row_q),
		.char_code (char_code),
		.upd       (upd)
	);

	assign in_ready  = (state_q == ST_IDLE) && !hold_valid_q;
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_take  = out_valid_q && out_ready;

	// protected rows beyond the screen act as all rows but the last
	assign keep       = (prot_q > KEEP_MAX) ? KEEP_MAX : prot_q;
	assign copy_start = tcw_pkg::cell_offset(keep, '0)
	                  + (tcw_pkg::ADDR_W+1)'(tcw_pkg::COLUMNS);

	// sequencer and store port control
	always_comb begin
		state_d   = state_q;
		col_d     = col_q;
		row_d     = row_q;
		cnt_d     = cnt_q;
		blank_d   = blank_q;
		rd_ok_d   = rd_ok_q;
		wr_v_d    = 1'b0;
		wr_addr_d = wr_addr_s1;
		mem_we    = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = blank_q;
		rd_en     = 1'b0;
		rd_addr   = cnt_q;
		res_fire  = 1'b0;
		res.col   = col_q;
		res.row   = row_q;
		res.word  = '0;
		res.scroll = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (op)
						tcw_pkg::OP_PUT: begin
							col_d     = upd.col;
							row_d     = upd.row;
							mem_we    = upd.cell_we;
							mem_waddr = upd.cell_addr;
							mem_wdata = {attr_q, char_code};
							if (upd.scroll) begin
								if (keep < KEEP_MAX) begin
									state_d = ST_COPY;
									cnt_d   = copy_start[tcw_pkg::ADDR_W-1:0];
								end else begin
									state_d = ST_ZERO;
									cnt_d   = LAST_BASE;
								end
							end else begin
								res_fire = 1'b1;
								res.col  = upd.col;
								res.row  = upd.row;
							end
						end
						tcw_pkg::OP_CLEAR: begin
							col_d   = '0;
							row_d   = '0;
							blank_d = {attr_q, tcw_pkg::CH_SPACE};
							cnt_d   = '0;
							state_d = ST_FILL;
						end
						tcw_pkg::OP_READ: begin
							rd_ok_d = cell_index < tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT);
							rd_en   = rd_ok_d;
							rd_addr = cell_index;
							state_d = ST_READ;
						end
						default: begin
							// unused op: report the cursor only
							res_fire = 1'b1;
						end
					endcase
				end
			end
			ST_READ: begin
				res_fire = 1'b1;
				res.word = rd_ok_q ? rdata_q : '0;
				state_d  = ST_IDLE;
			end
			ST_COPY: begin
				// read one row ahead, write back in the next cycle
				rd_en     = 1'b1;
				wr_v_d    = 1'b1;
				wr_addr_d = cnt_q - tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
				if (wr_v_s1) begin
					mem_we    = 1'b1;
					mem_waddr = wr_addr_s1;
					mem_wdata = rdata_q;
				end
				if (cnt_q == LAST_CELL) begin
					cnt_d   = LAST_BASE;
					state_d = ST_ZERO;
				end else begin
					cnt_d = cnt_q + tcw_pkg::ADDR_W'(1);
				end
			end
			ST_ZERO: begin
				// the last copy write drains first
				if (wr_v_s1) begin
					mem_we    = 1'b1;
					mem_waddr = wr_addr_s1;
					mem_wdata = rdata_q;
				end else begin
					mem_we    = 1'b1;
					mem_wdata = '0;
					if (cnt_q == LAST_CELL) begin
						res_fire   = 1'b1;
						res.scroll = 1'b1;
						state_d    = ST_IDLE;
					end else begin
						cnt_d = cnt_q + tcw_pkg::ADDR_W'(1);
					end
				end
			end
			ST_FILL: begin
				mem_we = 1'b1;
				if (cnt_q == LAST_CELL) begin
					res_fire = 1'b1;
					state_d  = ST_IDLE;
				end else begin
					cnt_d = cnt_q + tcw_pkg::ADDR_W'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		res_offset = tcw_pkg::cell_offset(res.row, res.col);
		res.offset = res_offset[tcw_pkg::ADDR_W-1:0];
	end

	// cell store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we)
			cells_mem[mem_waddr] <= mem_wdata;
		if (rd_en)
			rdata_q <= cells_mem[rd_addr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			col_q        <= '0;
			row_q        <= '0;
			attr_q       <= tcw_pkg::ATTR_W'(7);
			prot_q       <= tcw_pkg::PROT_W'(3);
			wr_v_s1      <= 1'b0;
			out_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			col_q   <= col_d;
			row_q   <= row_d;
			wr_v_s1 <= wr_v_d;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					tcw_pkg::CFG_ATTR: attr_q <= cfg_data;
					tcw_pkg::CFG_PROT: prot_q <= cfg_data[tcw_pkg::PROT_W-1:0];
					default: ;
				endcase
			end

			// result register and hold slot
			if (hold_valid_q) begin
				if (out_take)
					hold_valid_q <= 1'b0;
			end else if (res_fire) begin
				if (out_valid_q && !out_ready) begin
					hold_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		cnt_q      <= cnt_d;
		blank_q    <= blank_d;
		rd_ok_q    <= rd_ok_d;
		wr_addr_s1 <= wr_addr_d;
		if (hold_valid_q) begin
			if (out_take)
				out_q <= hold_q;
		end else if (res_fire) begin
			if (out_valid_q && !out_ready)
				hold_q <= res;
			else
				out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign cursor_col    = out_q.col;
	assign cursor_row    = out_q.row;
	assign cursor_offset = out_q.offset;
	assign cell_word     = out_q.word;
	assign did_scroll    = out_q.scroll;

	// a held item always sits behind a pending output item
	a_hold_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		hold_valid_q |-> out_valid_q)
		else $error("hold slot full with the output register empty");

	// copy write-back only runs inside a scroll
	a_copy_in_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		wr_v_s1 |-> (state_q == ST_COPY || state_q == ST_ZERO))
		else $error("copy write-back outside a scroll");

	// the cursor never rests on the last line
	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.row <= tcw_pkg::ROW_W'(tcw_pkg::ROWS - 2)))
		else $error("cursor row on the last line");

	// a scrolled item leaves the cursor on the line above the last
	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.scroll) |-> (out_q.row == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 2)))
		else $error("scroll left the cursor on the wrong row");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for text_console_writer_core: shadow console model, item
// driver with bursts and gaps, stalling result monitor. Depends on tcw_pkg and the RTL.
module tb;
	import tcw_pkg::*;

	// Codes the package leaves unnamed: spare op and spare register indexes
	localparam logic [1:0]        OP_SPARE     = 2'd3;
	localparam logic [CFG_IW-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IW-1:0] CFG_SPARE_HI = 2'd3;
	localparam int                TAIL_CYCLES  = 2100;
	localparam int                PHASES       = 11;
	localparam int                PHASE_ITEMS  = 150;

	typedef enum logic [1:0] {
		REQ_CMD   = 2'd0,
		REQ_REG   = 2'd1,
		REQ_DRAIN = 2'd2
	} req_kind_t;

	typedef struct packed {
		req_kind_t         kind;
		logic [1:0]        cmd;
		logic [CHAR_W-1:0] ch;
		logic [ADDR_W-1:0] ci;
		logic [CFG_IW-1:0] reg_idx;
		logic [CFG_DW-1:0] reg_val;
	} console_req_t;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                in_valid   = 1'b0;
	logic                in_ready;
	logic [1:0]          op         = '0;
	logic [CHAR_W-1:0]   char_code  = '0;
	logic [ADDR_W-1:0]   cell_index = '0;
	logic                out_valid;
	logic                out_ready  = 1'b0;
	logic [COL_W-1:0]    cursor_col;
	logic [ROW_W-1:0]    cursor_row;
	logic [ADDR_W-1:0]   cursor_offset;
	logic [WORD_W-1:0]   cell_word;
	logic                did_scroll;
	logic                cfg_valid  = 1'b0;
	logic                cfg_ready;
	logic [CFG_IW-1:0]   cfg_index  = '0;
	logic [CFG_DW-1:0]   cfg_data   = '0;

	// Shadow console state
	logic [WORD_W-1:0]   screen_model [CELL_COUNT];
	int                  cur_col     = 0;
	int                  cur_row     = 0;
	logic [ATTR_W-1:0]   attr_shadow = 8'd7;
	logic [PROT_W-1:0]   prot_shadow = 5'd3;

	console_req_t        console_reqs [$];
	result_t             screen_replies [$];
	int                  errors      = 0;
	bit                  live        = 1'b0;
	bit                  cmd_taken   = 1'b0;
	bit                  reg_taken   = 1'b0;
	bit                  stim_done   = 1'b0;
	int                  burst_left  = 4;
	int                  gap_left    = 0;
	int                  pat_left    = 0;
	logic [15:0]         stall_pat   = 16'hFFFF;

	text_console_writer_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.char_code     (char_code),
		.cell_index    (cell_index),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.cursor_col    (cursor_col),
		.cursor_row    (cursor_row),
		.cursor_offset (cursor_offset),
		.cell_word     (cell_word),
		.did_scroll    (did_scroll),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic flag_error(input string msg);
		errors++;
		if (errors <= 100)
			$display("mismatch at %0t ns: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
	                           input logic [15:0] want);
		if (got !== want)
			flag_error($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	// Bottom reached: shift the unprotected rows up, blank the last row
	function automatic bit scroll_if_bottom();
		int keep;
		if (cur_row < ROWS - 1)
			return 1'b0;
		keep = int'(prot_shadow);
		if (keep > ROWS - 1)
			keep = ROWS - 1;
		for (int r = keep; r + 1 < ROWS; r++)
			for (int c = 0; c < COLUMNS; c++)
				screen_model[r * COLUMNS + c] = screen_model[(r + 1) * COLUMNS + c];
		for (int c = 0; c < COLUMNS; c++)
			screen_model[(ROWS - 1) * COLUMNS + c] = '0;
		cur_row = ROWS - 2;
		return 1'b1;
	endfunction

	// Apply one accepted item to the shadow console and form its result
	task automatic advance_console(input logic [1:0] cmd, input logic [CHAR_W-1:0] ch,
	                               input logic [ADDR_W-1:0] ci, output result_t res);
		int          idx;
		int          off;
		bit          scrolled;
		logic [15:0] word;
		scrolled = 1'b0;
		word     = '0;
		if (cmd == OP_PUT) begin
			if (ch == CH_NEWLINE) begin
				cur_col = 0;
				cur_row++;
				scrolled = scroll_if_bottom();
			end else if (ch == CH_TAB) begin
				cur_col += TAB_STEP;
				if (cur_col > COLUMNS)
					cur_col = COLUMNS;
				scrolled = scroll_if_bottom();
			end else begin
				idx = cur_row * COLUMNS + cur_col;
				if (idx < CELL_COUNT)
					screen_model[idx] = {attr_shadow, ch};
				cur_col++;
				if (cur_col >= COLUMNS) begin
					cur_col = 0;
					cur_row++;
					if (cur_row >= ROWS)
						cur_row = 0;
					scrolled = scroll_if_bottom();
				end
			end
		end else if (cmd == OP_CLEAR) begin
			for (int i = 0; i < CELL_COUNT; i++)
				screen_model[i] = {attr_shadow, CH_SPACE};
			cur_col = 0;
			cur_row = 0;
		end else if (cmd == OP_READ) begin
			if (int'(ci) < CELL_COUNT)
				word = screen_model[ci];
		end
		off        = cur_row * COLUMNS + cur_col;
		res.col    = cur_col[COL_W-1:0];
		res.row    = cur_row[ROW_W-1:0];
		res.offset = off[ADDR_W-1:0];
		res.word   = word;
		res.scroll = scrolled;
	endtask

	task automatic push_cmd(input logic [1:0] cmd, input logic [CHAR_W-1:0] ch,
	                        input logic [ADDR_W-1:0] ci);
		console_req_t req;
		req         = '0;
		req.kind    = REQ_CMD;
		req.cmd     = cmd;
		req.ch      = ch;
		req.ci      = ci;
		console_reqs.push_back(req);
	endtask

	task automatic push_cfg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
		console_req_t req;
		req         = '0;
		req.kind    = REQ_REG;
		req.reg_idx = idx;
		req.reg_val = val;
		console_reqs.push_back(req);
	endtask

	// Rising edge: check results, record accepted items and register writes
	always @(posedge clk) begin : watch_ports
		result_t want;
		result_t fresh;
		live      = arst_n;
		cmd_taken = 1'b0;
		reg_taken = 1'b0;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (screen_replies.size() == 0) begin
					flag_error("result item with nothing expected");
				end else begin
					want = screen_replies.pop_front();
					check_field("cursor_col", 16'(cursor_col), 16'(want.col));
					check_field("cursor_row", 16'(cursor_row), 16'(want.row));
					check_field("cursor_offset", 16'(cursor_offset), 16'(want.offset));
					check_field("cell_word", cell_word, want.word);
					check_field("did_scroll", 16'(did_scroll), 16'(want.scroll));
				end
			end
			if (in_valid && in_ready) begin
				cmd_taken = 1'b1;
				advance_console(op, char_code, cell_index, fresh);
				screen_replies.push_back(fresh);
			end
			if (cfg_valid && cfg_ready) begin
				reg_taken = 1'b1;
				if (cfg_index == CFG_ATTR)
					attr_shadow = cfg_data;
				else if (cfg_index == CFG_PROT)
					prot_shadow = cfg_data[PROT_W-1:0];
			end
		end
	end

	// Falling edge: offer the next item, register write or idle-wait
	always @(negedge clk) begin : drive_items
		console_req_t req;
		if (!live) begin
			in_valid  <= 1'b0;
			cfg_valid <= 1'b0;
		end else if ((in_valid && !cmd_taken) || (cfg_valid && !reg_taken)) begin
			// item still on offer
		end else if (gap_left > 0) begin
			gap_left--;
			in_valid  <= 1'b0;
			cfg_valid <= 1'b0;
		end else if (console_reqs.size() == 0) begin
			in_valid  <= 1'b0;
			cfg_valid <= 1'b0;
			stim_done = 1'b1;
		end else if (console_reqs[0].kind != REQ_CMD && screen_replies.size() != 0) begin
			// block must be idle before a write or after a drain marker
			in_valid  <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			req = console_reqs.pop_front();
			case (req.kind)
				REQ_CMD: begin
					in_valid   <= 1'b1;
					cfg_valid  <= 1'b0;
					op         <= req.cmd;
					char_code  <= req.ch;
					cell_index <= req.ci;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 40 : 8);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
					end
				end
				REQ_REG: begin
					in_valid  <= 1'b0;
					cfg_valid <= 1'b1;
					cfg_index <= req.reg_idx;
					cfg_data  <= req.reg_val;
				end
				default: begin
					in_valid  <= 1'b0;
					cfg_valid <= 1'b0;
				end
			endcase
		end
	end

	// Receiver stalls on a rotating pattern, reloaded now and then
	always @(negedge clk) begin : pace_receiver
		if (pat_left == 0) begin
			pat_left = $urandom_range(20, 200);
			if ($urandom_range(0, 3) == 0) begin
				stall_pat = 16'hFFFF;
			end else begin
				stall_pat = 16'($urandom);
				if (stall_pat == 16'h0000)
					stall_pat = 16'h0001;
			end
		end
		pat_left--;
		stall_pat = {stall_pat[14:0], stall_pat[15]};
		out_ready <= stall_pat[0];
	end

	// Stimulus list, reset and end of run
	initial begin : run_console
		console_req_t drain;
		int           pick;
		int           kind_roll;
		logic [1:0]   cmd;
		logic [7:0]   ch;
		logic [10:0]  ci;
		logic [7:0]   attr;
		logic [4:0]   prot;
		drain      = '0;
		drain.kind = REQ_DRAIN;

		// Directed: put before any clear, spare op, clear, read extremes
		push_cmd(OP_PUT, 8'h41, 11'd0);
		push_cmd(OP_SPARE, 8'hFF, 11'h7FF);
		push_cmd(OP_CLEAR, 8'h00, 11'd0);
		push_cmd(OP_READ, 8'h00, 11'd0);
		push_cmd(OP_READ, 8'hFF, 11'(CELL_COUNT - 1));
		push_cmd(OP_READ, 8'h00, 11'(CELL_COUNT));
		push_cmd(OP_READ, 8'h00, 11'h7FF);
		push_cmd(OP_PUT, 8'h00, 11'h7FF);
		push_cmd(OP_PUT, 8'hFF, 11'd0);
		push_cmd(OP_READ, 8'h00, 11'd0);
		push_cmd(OP_READ, 8'h00, 11'd1);
		// tabs until the column clamps at the width, then a put at that column
		for (int i = 0; i < 8; i++)
			push_cmd(OP_PUT, CH_TAB, 11'd0);
		push_cmd(OP_PUT, 8'h7E, 11'd0);
		push_cmd(OP_READ, 8'h00, 11'(COLUMNS));
		push_cmd(OP_PUT, CH_NEWLINE, 11'd0);
		push_cmd(OP_READ, 8'h00, 11'(COLUMNS + 1));
		push_cfg(CFG_SPARE_LO, 8'h5A);
		push_cfg(CFG_SPARE_HI, 8'hFF);

		// Random phases, each behind new register settings
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0:       attr = 8'h00;
				1:       attr = 8'hFF;
				default: attr = 8'($urandom_range(0, 255));
			endcase
			case (p % 6)
				0:       prot = 5'd0;
				1:       prot = 5'd23;
				2:       prot = 5'd31;
				3:       prot = 5'd24;
				4:       prot = 5'd3;
				default: prot = 5'($urandom_range(0, 31));
			endcase
			push_cfg(CFG_ATTR, attr);
			push_cfg(CFG_PROT, {3'b000, prot});
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2)
					console_reqs.push_back(drain);
				pick = $urandom_range(0, 99);
				ch   = 8'($urandom_range(0, 255));
				ci   = 11'($urandom_range(0, 2047));
				if (pick < 2) begin
					cmd = OP_CLEAR;
				end else if (pick < 3) begin
					cmd = OP_SPARE;
				end else if (pick < 25) begin
					cmd       = OP_READ;
					kind_roll = $urandom_range(0, 9);
					if (kind_roll == 0)
						ci = 11'($urandom_range(CELL_COUNT, 2047));
					else if (kind_roll < 5)
						ci = 11'($urandom_range(CELL_COUNT - 5 * COLUMNS, CELL_COUNT - 1));
					else
						ci = 11'($urandom_range(0, CELL_COUNT - 1));
				end else begin
					cmd       = OP_PUT;
					kind_roll = $urandom_range(0, 99);
					if (kind_roll < 10)
						ch = CH_NEWLINE;
					else if (kind_roll < 18)
						ch = CH_TAB;
				end
				push_cmd(cmd, ch, ci);
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (stim_done && screen_replies.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && screen_replies.size() == 0)
			$display("PASS text_console_writer_core");
		else
			$display("FAIL text_console_writer_core");
		$finish;
	end

	// Hard limit on the run
	initial begin : watchdog
		#30_000_000;
		$display("FAIL text_console_writer_core");
		$finish;
	end

endmodule
